// ===== src/lfpid_pkg.sv =====
package lfpid_pkg;

  localparam int INTEG_W  = 16;
  localparam int ERR_W    = 7;
  localparam int DERIV_W  = ERR_W + 1;
  localparam int GAIN_W   = 12;
  localparam int SPD_W    = 8;
  localparam int DUR_W    = 8;
  localparam int SENS_N   = 6;
  localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W = GAIN_W + 1 + INTEG_W;
  localparam int PROD_D_W = GAIN_W + 1 + DERIV_W;
  localparam int SUM_W    = PROD_I_W + 2;
  localparam int FRAC_W   = 8;
  localparam int CORR_W   = SUM_W - FRAC_W;
  localparam int SPDX_W   = CORR_W + 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH = 3'd6;

  localparam logic [GAIN_W-1:0] KP_RST     = 12'd154;
  localparam logic [GAIN_W-1:0] KI_RST     = 12'd26;
  localparam logic [GAIN_W-1:0] KD_RST     = 12'd77;
  localparam logic [SPD_W-1:0]  BASE_RST   = 8'd150;
  localparam logic [SPD_W-1:0]  MAX_RST    = 8'd200;
  localparam logic [SPD_W-1:0]  TURN_RST   = 8'd180;
  localparam logic [SPD_W-1:0]  SEARCH_RST = 8'd120;

  localparam logic [DUR_W-1:0] SEARCH_MS = 8'd120;
  localparam logic [DUR_W-1:0] TURN_MS   = 8'd180;
  localparam logic [DUR_W-1:0] PID_MS    = 8'd120;

  localparam logic signed [ERR_W-1:0] WEIGHT [SENS_N] =
    '{-7'sd20, -7'sd10, -7'sd5, 7'sd5, 7'sd10, 7'sd20};

  typedef enum logic [1:0] {
    ACT_DRIVE = 2'd0,
    ACT_LEFT  = 2'd1,
    ACT_RIGHT = 2'd2,
    ACT_BACK  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    KIND_PID    = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_TURN   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SRCH_IDLE     = 2'd0,
    SRCH_RIGHT2   = 2'd1,
    SRCH_LEFTBACK = 2'd2,
    SRCH_BACK     = 2'd3
  } srch_t;

  typedef struct packed {
    kind_t                    kind;
    act_t                     action;
    logic signed [ERR_W-1:0]  err;
    logic                     last;
  } cmd_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic [SPD_W-1:0]  base_speed;
    logic [SPD_W-1:0]  max_speed;
    logic [SPD_W-1:0]  turn_speed;
    logic [SPD_W-1:0]  search_speed;
  } cfg_t;

  function automatic logic signed [ERR_W-1:0] sensor_error(input logic [SENS_N-1:0] s);
    logic signed [ERR_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < SENS_N; i++) begin
      if (s[i]) begin
        acc = acc + WEIGHT[i];
      end
    end
    return acc;
  endfunction

endpackage

// ===== src/lfpid_in_if.sv =====
interface lfpid_in_if import lfpid_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SENS_N-1:0] sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink   (input valid, input sensor_bits, output ready);
endinterface

// ===== src/lfpid_out_if.sv =====
interface lfpid_out_if import lfpid_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [SPD_W-1:0] left_speed;
  logic [SPD_W-1:0] right_speed;
  logic [DUR_W-1:0] duration_ms;
  logic             last;

  modport source (output valid, output action, output left_speed, output right_speed,
                  output duration_ms, output last, input ready);
  modport sink   (input valid, input action, input left_speed, input right_speed,
                  input duration_ms, input last, output ready);
endinterface

// ===== src/lfpid_front.sv =====
module lfpid_front import lfpid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lfpid_in_if.sink    in_scan,
  input  logic        q_full,
  output logic        push_v,
  output cmd_t        push_cmd
);

  srch_t step_r, step_nxt;
  logic  pend_v_r, pend_v_nxt;
  cmd_t  pend_r, pend_nxt;
  cmd_t  new_cmd;
  logic  acc;
  logic  hit_left, hit_right;
  logic signed [ERR_W-1:0] err;

  assign err       = sensor_error(in_scan.sensor_bits);
  assign hit_left  = in_scan.sensor_bits[0] || (in_scan.sensor_bits[2:1] == 2'b11);
  assign hit_right = in_scan.sensor_bits[5] || (in_scan.sensor_bits[4:3] == 2'b11);
  assign in_scan.ready = !pend_v_r && !q_full;
  assign acc = in_scan.valid && in_scan.ready;

  always_comb begin
    step_nxt   = step_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    new_cmd    = '{kind: KIND_PID, action: ACT_DRIVE, err: err, last: 1'b1};
    if (pend_v_r && !q_full) begin
      pend_v_nxt = 1'b0;
    end
    if (acc) begin
      if (in_scan.sensor_bits == '0) begin
        new_cmd.kind = KIND_SEARCH;
        new_cmd.err  = '0;
        case (step_r)
          SRCH_IDLE: begin
            new_cmd.action = ACT_LEFT;
            step_nxt       = SRCH_RIGHT2;
          end
          SRCH_RIGHT2: begin
            new_cmd.action = ACT_RIGHT;
            new_cmd.last   = 1'b0;
            pend_v_nxt     = 1'b1;
            pend_nxt       = '{kind: KIND_SEARCH, action: ACT_RIGHT, err: '0, last: 1'b1};
            step_nxt       = SRCH_LEFTBACK;
          end
          SRCH_LEFTBACK: begin
            new_cmd.action = ACT_LEFT;
            new_cmd.last   = 1'b0;
            pend_v_nxt     = 1'b1;
            pend_nxt       = '{kind: KIND_SEARCH, action: ACT_BACK, err: '0, last: 1'b1};
            step_nxt       = SRCH_BACK;
          end
          SRCH_BACK: begin
            new_cmd.action = ACT_BACK;
            step_nxt       = SRCH_IDLE;
          end
          default: begin
            step_nxt = SRCH_IDLE;
          end
        endcase
      end else begin
        step_nxt = SRCH_IDLE;
        if (hit_left) begin
          new_cmd.kind   = KIND_TURN;
          new_cmd.action = ACT_LEFT;
        end else if (hit_right) begin
          new_cmd.kind   = KIND_TURN;
          new_cmd.action = ACT_RIGHT;
        end
      end
    end
  end

  assign push_v   = pend_v_r ? !q_full : acc;
  assign push_cmd = pend_v_r ? pend_r : new_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= SRCH_IDLE;
      pend_v_r <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

`ifndef SYNTH
  a_pend_origin: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r && !$past(pend_v_r) |->
      $past(in_scan.valid && in_scan.ready && (in_scan.sensor_bits == '0)))
    else $error("second search word without an empty scan");
`endif

endmodule

// ===== src/lfpid_queue.sv =====
module lfpid_queue import lfpid_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_v,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_v,
  output cmd_t head_cmd
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign head_v   = (cnt_r != '0);
  assign head_cmd = mem_r[rd_ptr_r];
  assign do_push  = push_v && !full;
  assign do_pop   = pop && head_v;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_v |-> !full)
    else $error("push into full queue");
`endif

endmodule

// ===== src/lfpid_back.sv =====
module lfpid_back import lfpid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        head_v,
  input  cmd_t        head_cmd,
  output logic        pop,
  lfpid_out_if.source out_cmd
);

  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]   prev_r, prev_nxt;
  logic signed [INTEG_W:0]   integ_ext;
  logic signed [DERIV_W-1:0] deriv;

  logic                        a_v_r, b_v_r, c_v_r, o_v_r;
  logic                        a_adv, b_adv, c_adv, o_adv;
  cmd_t                        a_cmd_r, b_cmd_r, c_cmd_r;
  logic signed [INTEG_W-1:0]   a_integ_r;
  logic signed [DERIV_W-1:0]   a_der_r;
  logic signed [PROD_P_W-1:0]  b_pp_r, pp;
  logic signed [PROD_I_W-1:0]  b_pi_r, pi;
  logic signed [PROD_D_W-1:0]  b_pd_r, pd;
  logic signed [SUM_W-1:0]     sum, sum_adj;
  logic signed [CORR_W-1:0]    c_corr_r;
  logic signed [SPDX_W-1:0]    base_x, max_x, left_x, right_x;

  logic [1:0]       o_act_r, o_act_nxt;
  logic [SPD_W-1:0] o_left_r, o_left_nxt, o_right_r, o_right_nxt;
  logic [DUR_W-1:0] o_dur_r, o_dur_nxt;
  logic             o_last_r;

  assign o_adv = !o_v_r || out_cmd.ready;
  assign c_adv = !c_v_r || o_adv;
  assign b_adv = !b_v_r || c_adv;
  assign a_adv = !a_v_r || b_adv;
  assign pop   = head_v && a_adv;

  // integral saturation and derivative at pop
  assign integ_ext = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(head_cmd.err);
  assign deriv     = DERIV_W'(head_cmd.err) - DERIV_W'(prev_r);

  always_comb begin
    integ_nxt = integ_r;
    prev_nxt  = prev_r;
    if (pop) begin
      if (head_cmd.kind == KIND_PID) begin
        if (integ_ext[INTEG_W] != integ_ext[INTEG_W-1]) begin
          integ_nxt = integ_ext[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                         : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
          integ_nxt = integ_ext[INTEG_W-1:0];
        end
        prev_nxt = head_cmd.err;
      end else begin
        integ_nxt = '0;
        prev_nxt  = '0;
      end
    end
  end

  assign pp = PROD_P_W'($signed({1'b0, cfg.kp_gain})) * PROD_P_W'(a_cmd_r.err);
  assign pi = PROD_I_W'($signed({1'b0, cfg.ki_gain})) * PROD_I_W'(a_integ_r);
  assign pd = PROD_D_W'($signed({1'b0, cfg.kd_gain})) * PROD_D_W'(a_der_r);

  // Q.8 sum, truncated toward zero
  assign sum     = SUM_W'(b_pp_r) + SUM_W'(b_pi_r) + SUM_W'(b_pd_r);
  assign sum_adj = sum + (sum[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));

  assign base_x  = SPDX_W'($signed({1'b0, cfg.base_speed}));
  assign max_x   = SPDX_W'($signed({1'b0, cfg.max_speed}));
  assign left_x  = base_x - SPDX_W'(c_corr_r);
  assign right_x = base_x + SPDX_W'(c_corr_r);

  always_comb begin
    o_act_nxt   = c_cmd_r.action;
    o_left_nxt  = cfg.search_speed;
    o_right_nxt = cfg.search_speed;
    o_dur_nxt   = SEARCH_MS;
    case (c_cmd_r.kind)
      KIND_PID: begin
        o_dur_nxt = PID_MS;
        if (left_x < 0) begin
          o_left_nxt = '0;
        end else if (left_x > max_x) begin
          o_left_nxt = cfg.max_speed;
        end else begin
          o_left_nxt = left_x[SPD_W-1:0];
        end
        if (right_x < 0) begin
          o_right_nxt = '0;
        end else if (right_x > max_x) begin
          o_right_nxt = cfg.max_speed;
        end else begin
          o_right_nxt = right_x[SPD_W-1:0];
        end
      end
      KIND_TURN: begin
        o_left_nxt  = cfg.turn_speed;
        o_right_nxt = cfg.turn_speed;
        o_dur_nxt   = TURN_MS;
      end
      default: begin
        o_dur_nxt = SEARCH_MS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      o_v_r   <= 1'b0;
    end else begin
      integ_r <= integ_nxt;
      prev_r  <= prev_nxt;
      if (a_adv) begin
        a_v_r <= pop;
      end
      if (b_adv) begin
        b_v_r <= a_v_r;
      end
      if (c_adv) begin
        c_v_r <= b_v_r;
      end
      if (o_adv) begin
        o_v_r <= c_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_cmd_r   <= head_cmd;
      a_integ_r <= integ_nxt;
      a_der_r   <= deriv;
    end
    if (b_adv && a_v_r) begin
      b_cmd_r <= a_cmd_r;
      b_pp_r  <= pp;
      b_pi_r  <= pi;
      b_pd_r  <= pd;
    end
    if (c_adv && b_v_r) begin
      c_cmd_r  <= b_cmd_r;
      c_corr_r <= sum_adj[SUM_W-1:FRAC_W];
    end
    if (o_adv && c_v_r) begin
      o_act_r   <= o_act_nxt;
      o_left_r  <= o_left_nxt;
      o_right_r <= o_right_nxt;
      o_dur_r   <= o_dur_nxt;
      o_last_r  <= c_cmd_r.last;
    end
  end

  assign out_cmd.valid       = o_v_r;
  assign out_cmd.action      = o_act_r;
  assign out_cmd.left_speed  = o_left_r;
  assign out_cmd.right_speed = o_right_r;
  assign out_cmd.duration_ms = o_dur_r;
  assign out_cmd.last        = o_last_r;

`ifndef SYNTH
  a_pid_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (head_cmd.kind != KIND_PID) |=> (integ_r == '0) && (prev_r == '0))
    else $error("PID state not cleared on search or turn");
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && !b_adv |=> a_v_r && $stable(a_cmd_r) && $stable(a_integ_r))
    else $error("stalled stage lost its word");
`endif

endmodule

// ===== src/line_follower_pid_controller.sv =====
// Line follower controller with PID steering.
// in_scan: one word per scan of six line sensors (sensor_bits, bit 0 leftmost),
//   valid/ready handshake. A scan with no line seen in the middle of the search
//   sequence yields two command words; every other scan yields one.
// out_cmd: command words (action, left_speed, right_speed, duration_ms, last),
//   valid/ready handshake; last marks the final word of a scan.
// cfg_*: register write port, one write per cycle while cfg_we is high;
//   index 0..6 = kp, ki, kd, base, max, turn, search speed; others ignored.
// Path: the first word of a scan is pushed into the queue, then passes the
//   integral update, products, sum and clamp stages to the output register.
// Throughput: one command word per cycle on the output while out_cmd.ready is
//   high; a one-word scan can be taken every cycle while the queue has room, a
//   two-word scan holds the input until its second word is in the 4-entry queue.
// Reset (rst_n low, synchronous): registers return to defaults, integral,
//   last error and search step clear, queue and pipeline empty.
// Output stall: the pipeline and queue hold their words; the input drops
//   ready once the queue fills.
module line_follower_pid_controller import lfpid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lfpid_in_if.sink              in_scan,
  lfpid_out_if.source           out_cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_full, push_v, pop, head_v;
  cmd_t push_cmd, head_cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_KP:     cfg_nxt.kp_gain      = cfg_data[GAIN_W-1:0];
        REG_KI:     cfg_nxt.ki_gain      = cfg_data[GAIN_W-1:0];
        REG_KD:     cfg_nxt.kd_gain      = cfg_data[GAIN_W-1:0];
        REG_BASE:   cfg_nxt.base_speed   = cfg_data[SPD_W-1:0];
        REG_MAX:    cfg_nxt.max_speed    = cfg_data[SPD_W-1:0];
        REG_TURN:   cfg_nxt.turn_speed   = cfg_data[SPD_W-1:0];
        REG_SEARCH: cfg_nxt.search_speed = cfg_data[SPD_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{kp_gain: KP_RST, ki_gain: KI_RST, kd_gain: KD_RST,
                 base_speed: BASE_RST, max_speed: MAX_RST,
                 turn_speed: TURN_RST, search_speed: SEARCH_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lfpid_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_scan  (in_scan),
    .q_full   (q_full),
    .push_v   (push_v),
    .push_cmd (push_cmd)
  );

  lfpid_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_v   (push_v),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head_v   (head_v),
    .head_cmd (head_cmd)
  );

  lfpid_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head_v   (head_v),
    .head_cmd (head_cmd),
    .pop      (pop),
    .out_cmd  (out_cmd)
  );

endmodule

// ===== sim/lfpid_cmd_checker.sv =====
`timescale 1ns / 100ps

module lfpid_cmd_checker import lfpid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  scan_valid,
  input  logic                  scan_ready,
  input  logic [SENS_N-1:0]     scan_bits,
  input  logic                  cmd_valid,
  input  logic                  cmd_ready,
  input  logic [1:0]            cmd_action,
  input  logic [SPD_W-1:0]      cmd_left,
  input  logic [SPD_W-1:0]      cmd_right,
  input  logic [DUR_W-1:0]      cmd_dur,
  input  logic                  cmd_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    words_due
);

  typedef struct packed {
    act_t             action;
    logic [SPD_W-1:0] left;
    logic [SPD_W-1:0] right;
    logic [DUR_W-1:0] dur;
    logic             last;
  } cmd_word_t;

  localparam int SENSOR_WT [SENS_N] = '{-20, -10, -5, 5, 10, 20};

  cmd_word_t                due_cmds [$];
  cmd_word_t                got;
  cfg_t                     regs;
  logic signed [INTEG_W-1:0] integ;
  logic signed [ERR_W-1:0]  prev_err;
  srch_t                    step;
  int                       fails = 0;

  function automatic logic [SPD_W-1:0] clamp_speed(input longint v);
    if (v < 0) begin
      return '0;
    end
    if (v > longint'(regs.max_speed)) begin
      return regs.max_speed;
    end
    return v[SPD_W-1:0];
  endfunction

  task automatic push_cmd(input act_t a, input logic [SPD_W-1:0] l, input logic [SPD_W-1:0] r,
                          input logic [DUR_W-1:0] d, input logic fin);
    cmd_word_t w;
    w.action = a;
    w.left   = l;
    w.right  = r;
    w.dur    = d;
    w.last   = fin;
    due_cmds.push_back(w);
  endtask

  task automatic derive_commands(input logic [SENS_N-1:0] s);
    int               err;
    longint           acc;
    longint           hi;
    longint           lo;
    longint           deriv;
    longint           sum;
    longint           corr;
    logic [SPD_W-1:0] sp;
    err = 0;
    for (int i = 0; i < SENS_N; i++) begin
      if (s[i]) begin
        err += SENSOR_WT[i];
      end
    end
    if (s == '0) begin
      sp = regs.search_speed;
      case (step)
        SRCH_IDLE: begin
          push_cmd(ACT_LEFT, sp, sp, SEARCH_MS, 1'b1);
          step = SRCH_RIGHT2;
        end
        SRCH_RIGHT2: begin
          push_cmd(ACT_RIGHT, sp, sp, SEARCH_MS, 1'b0);
          push_cmd(ACT_RIGHT, sp, sp, SEARCH_MS, 1'b1);
          step = SRCH_LEFTBACK;
        end
        SRCH_LEFTBACK: begin
          push_cmd(ACT_LEFT, sp, sp, SEARCH_MS, 1'b0);
          push_cmd(ACT_BACK, sp, sp, SEARCH_MS, 1'b1);
          step = SRCH_BACK;
        end
        default: begin
          push_cmd(ACT_BACK, sp, sp, SEARCH_MS, 1'b1);
          step = SRCH_IDLE;
        end
      endcase
      integ    = '0;
      prev_err = '0;
    end else begin
      step = SRCH_IDLE;
      if (s[0] || s[2:1] == 2'b11) begin
        push_cmd(ACT_LEFT, regs.turn_speed, regs.turn_speed, TURN_MS, 1'b1);
        integ    = '0;
        prev_err = '0;
      end else if (s[5] || s[4:3] == 2'b11) begin
        push_cmd(ACT_RIGHT, regs.turn_speed, regs.turn_speed, TURN_MS, 1'b1);
        integ    = '0;
        prev_err = '0;
      end else begin
        hi  = (longint'(1) <<< (INTEG_W - 1)) - 1;
        lo  = -hi - 1;
        acc = longint'(integ) + err;
        if (acc > hi) begin
          acc = hi;
        end
        if (acc < lo) begin
          acc = lo;
        end
        integ = acc[INTEG_W-1:0];
        deriv = err - longint'(prev_err);
        sum   = longint'(regs.kp_gain) * err + longint'(regs.ki_gain) * acc
              + longint'(regs.kd_gain) * deriv;
        corr  = sum / 256;
        prev_err = err[ERR_W-1:0];
        push_cmd(ACT_DRIVE, clamp_speed(longint'(regs.base_speed) - corr),
                 clamp_speed(longint'(regs.base_speed) + corr), PID_MS, 1'b1);
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] expv,
                                      input logic [7:0] gotv);
    if (gotv !== expv) begin
      $display("%0t cmd %s mismatch: expected %0d, actual %0d", $time, name, expv, gotv);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.kp_gain      = KP_RST;
      regs.ki_gain      = KI_RST;
      regs.kd_gain      = KD_RST;
      regs.base_speed   = BASE_RST;
      regs.max_speed    = MAX_RST;
      regs.turn_speed   = TURN_RST;
      regs.search_speed = SEARCH_RST;
      integ    = '0;
      prev_err = '0;
      step     = SRCH_IDLE;
      due_cmds.delete();
      words_due <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KP:     regs.kp_gain      = cfg_data;
          REG_KI:     regs.ki_gain      = cfg_data;
          REG_KD:     regs.kd_gain      = cfg_data;
          REG_BASE:   regs.base_speed   = cfg_data[SPD_W-1:0];
          REG_MAX:    regs.max_speed    = cfg_data[SPD_W-1:0];
          REG_TURN:   regs.turn_speed   = cfg_data[SPD_W-1:0];
          REG_SEARCH: regs.search_speed = cfg_data[SPD_W-1:0];
          default: ;
        endcase
      end
      if (scan_valid && scan_ready) begin
        derive_commands(scan_bits);
      end
      if (cmd_valid && cmd_ready) begin
        if (due_cmds.size() == 0) begin
          $display("%0t unexpected cmd word: action %0d left %0d right %0d dur %0d last %0d",
                   $time, cmd_action, cmd_left, cmd_right, cmd_dur, cmd_last);
          fails++;
        end else begin
          got = due_cmds.pop_front();
          check_field("action", 8'(got.action), 8'(cmd_action));
          check_field("left_speed", got.left, cmd_left);
          check_field("right_speed", got.right, cmd_right);
          check_field("duration_ms", got.dur, cmd_dur);
          check_field("last", 8'(got.last), 8'(cmd_last));
        end
      end
      words_due <= due_cmds.size();
    end
    fail_count <= fails;
  end

endmodule

// ===== sim/line_follower_pid_controller_tb.sv =====
`timescale 1ns / 100ps

module line_follower_pid_controller_tb;
  import lfpid_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int LONG_HOLD = 200;
  localparam int SAT_RUN   = 150;
  localparam logic [SENS_N-1:0] DIRECTED [26] = '{
    6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd8, 6'd0,
    6'd1, 6'd6, 6'd7, 6'd32, 6'd24, 6'd63,
    6'd2, 6'd4, 6'd8, 6'd16, 6'd10, 6'd20, 6'd18, 6'd12,
    6'd16, 6'd16, 6'd2
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    words_due;
  int                    hold_req = 0;
  int                    hold_done = 0;
  int                    burst_left = 0;
  int                    zero_run = 0;
  bit                    bursty = 1'b1;

  lfpid_in_if  in_scan ();
  lfpid_out_if out_cmd ();

  always #6 clk = ~clk;

  line_follower_pid_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_scan   (in_scan),
    .out_cmd   (out_cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lfpid_cmd_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_valid (in_scan.valid),
    .scan_ready (in_scan.ready),
    .scan_bits  (in_scan.sensor_bits),
    .cmd_valid  (out_cmd.valid),
    .cmd_ready  (out_cmd.ready),
    .cmd_action (out_cmd.action),
    .cmd_left   (out_cmd.left_speed),
    .cmd_right  (out_cmd.right_speed),
    .cmd_dur    (out_cmd.duration_ms),
    .cmd_last   (out_cmd.last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  function automatic int next_gap();
    if (!bursty) begin
      return 0;
    end
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 40);
    return $urandom_range(1, 12);
  endfunction

  // mostly steering patterns, with lost-line runs and raw noise
  function automatic logic [SENS_N-1:0] random_scan();
    int                r;
    logic [SENS_N-1:0] b;
    if (zero_run > 0) begin
      zero_run--;
      return '0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      zero_run = $urandom_range(0, 4);
      return '0;
    end
    if (r < 25) begin
      return SENS_N'($urandom_range(0, 63));
    end
    do begin
      b = {1'b0, 4'($urandom_range(1, 15)), 1'b0};
    end while (b[2:1] == 2'b11 || b[4:3] == 2'b11);
    return b;
  endfunction

  function automatic int rand_cfg(input int maxv);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 0;
    end
    if (r == 1) begin
      return maxv;
    end
    return $urandom_range(0, maxv);
  endfunction

  task automatic send_scan(input logic [SENS_N-1:0] s);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_scan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_scan.valid       <= 1'b1;
    in_scan.sensor_bits <= s;
    @(posedge clk);
    while (!in_scan.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_scan.valid <= 1'b0;
    @(posedge clk);
    wait (words_due == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] speed_word(input int v);
    return {4'($urandom_range(0, 15)), 8'(v)};
  endfunction

  task automatic apply_config(input int kp, input int ki, input int kd, input int base,
                              input int maxs, input int turn, input int search);
    drain();
    write_reg(REG_KP, CFG_DATA_W'(kp));
    write_reg(REG_KI, CFG_DATA_W'(ki));
    write_reg(REG_KD, CFG_DATA_W'(kd));
    write_reg(REG_BASE, speed_word(base));
    write_reg(REG_MAX, speed_word(maxs));
    write_reg(REG_TURN, speed_word(turn));
    write_reg(REG_SEARCH, speed_word(search));
    write_reg(REG_NONE, CFG_DATA_W'($urandom_range(0, 4095)));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_scans(input int n);
    repeat (n) send_scan(random_scan());
  endtask

  // receiver: stretches of always-ready, light and heavy stalls, fixed pattern
  initial begin
    int mode;
    int len;
    int k;
    int tick;
    out_cmd.ready = 1'b0;
    tick = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req != hold_done) begin
        out_cmd.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done++;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(20, 120);
        for (k = 0; k < len && hold_req == hold_done; k++) begin
          case (mode)
            0: out_cmd.ready <= 1'b1;
            1: out_cmd.ready <= ($urandom_range(0, 3) != 0);
            2: out_cmd.ready <= ($urandom_range(0, 3) == 0);
            default: out_cmd.ready <= (tick % 5 < 2);
          endcase
          tick++;
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    in_scan.valid       = 1'b0;
    in_scan.sensor_bits = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) send_scan(DIRECTED[i]);

    apply_config(4095, 4095, 4095, 255, 255, 255, 255);
    random_scans(150);

    apply_config(0, 0, 0, 0, 0, 0, 0);
    random_scans(100);

    // output held off while scans keep coming
    apply_config(rand_cfg(4095), rand_cfg(4095), rand_cfg(4095), rand_cfg(255),
                 rand_cfg(255), rand_cfg(255), rand_cfg(255));
    bursty = 1'b0;
    hold_req++;
    random_scans(40);
    bursty = 1'b1;

    repeat (4) begin
      apply_config(rand_cfg(4095), rand_cfg(4095), rand_cfg(4095), rand_cfg(255),
                   rand_cfg(255), rand_cfg(255), rand_cfg(255));
      random_scans(130);
    end

    // long one-sided integral runs in both directions
    apply_config(0, 1, 0, 128, 255, 90, 60);
    bursty = 1'b0;
    repeat (SAT_RUN) send_scan(6'd16);
    send_scan(6'd1);
    repeat (SAT_RUN) send_scan(6'd2);
    bursty = 1'b1;
    random_scans(20);

    apply_config(int'(KP_RST), int'(KI_RST), int'(KD_RST), int'(BASE_RST),
                 int'(MAX_RST), int'(TURN_RST), int'(SEARCH_RST));
    random_scans(100);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lfpid_pkg.sv
src/lfpid_in_if.sv
src/lfpid_out_if.sv
src/lfpid_front.sv
src/lfpid_queue.sv
src/lfpid_back.sv
src/line_follower_pid_controller.sv
sim/lfpid_cmd_checker.sv
sim/line_follower_pid_controller_tb.sv
